### sv/smat_pkg.sv
// Package for the servo midpoint auto trim block.
// Holds widths, reset values, phase codes and register indexes.
// No dependencies; used by servo_midpoint_autotrim.
`default_nettype none

package smat_pkg;

    // Field widths
    localparam int MID_W  = 12;
    localparam int SUM_W  = 32;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int PH_W   = 2;

    // Servo count range is 1 to 8
    localparam int NUM_SERVOS_DEF = 4;

    // Reset values
    localparam logic [MID_W-1:0] MID_RESET   = MID_W'(1500);
    localparam logic [MID_W-1:0] MID_MAX     = {MID_W{1'b1}};
    localparam logic [CFG_W-1:0] COLLECT_DEF = CFG_W'(2000);
    localparam logic [CFG_W-1:0] SAVE_DEF    = CFG_W'(2500);

    // Trim phase codes
    localparam logic [PH_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PH_W-1:0] PH_COLLECT = 2'd1;
    localparam logic [PH_W-1:0] PH_SAVE    = 2'd2;
    localparam logic [PH_W-1:0] PH_DONE    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_COLLECT_TIME = 1'b0;
    localparam logic CFG_SAVE_DELAY   = 1'b1;

endpackage

`default_nettype wire

### sv/smat_ram.sv
// Generic single write port RAM with a registered read port.
// Standalone; no package needed.
`default_nettype none

module smat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/servo_midpoint_autotrim.sv
// Servo midpoint auto trim: top level with the per-servo sequencer and divider.
// Depends on smat_pkg and smat_ram.
//
//  channel  | dir | handshake                         | payload
//  ---------+-----+-----------------------------------+------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready | pulses, armed, enable, now_ms
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready | midpoints, phase, pulses out
//  cfg      | in  | i_cfg_wr_en (no wait)             | i_cfg_idx, i_cfg_wdata
//
// Each item walks all servos through the entry RAM, with a read and an update state
// per servo. On a tick that computes the midpoints, each servo also runs a bit-serial
// 32-bit divide and a write-back state.
// Reset is synchronous; the RAM needs no clearing pass, per-entry valid bits stand in
// for the midpoint reset value. A new item is taken while a result waits on m_axis.
`default_nettype none

module servo_midpoint_autotrim #(
    parameter int NUM_SERVOS = smat_pkg::NUM_SERVOS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // pulse_0..pulse_(N-1) (12b each), armed, trim_enable, now_ms (32b), zero pad
    input  wire logic [((12*NUM_SERVOS+34+7)/8)*8-1:0] i_s_axis_tdata,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // middle_0..middle_(N-1) (12b each), phase (2b), save_pulse,
    // integral_reset_pulse, success_beep, zero pad
    output logic      [((12*NUM_SERVOS+5+7)/8)*8-1:0] o_m_axis_tdata,
    output logic      o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_idx,
    input  wire logic [smat_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int MID_W   = smat_pkg::MID_W;
    localparam int SUM_W   = smat_pkg::SUM_W;
    localparam int TIME_W  = smat_pkg::TIME_W;
    localparam int PH_W    = smat_pkg::PH_W;
    localparam int IDX_W   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int ENT_W   = 2*MID_W + SUM_W;
    localparam int ARM_B   = MID_W*NUM_SERVOS;
    localparam int CNT_W   = $clog2(SUM_W);

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MOD, ST_DIV, ST_WB, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE, OP_BACKUP, OP_ACC, OP_RESTORE
    } t_op;

    // Control registers
    t_state                 r_state;
    logic [PH_W-1:0]        r_phase;
    logic [SUM_W-1:0]       r_tick;
    logic [TIME_W-1:0]      r_collect_start;
    logic [TIME_W-1:0]      r_save_mark;
    logic [smat_pkg::CFG_W-1:0] r_collect_ms;
    logic [smat_pkg::CFG_W-1:0] r_save_ms;
    logic [NUM_SERVOS-1:0]  r_mid_vld;
    logic                   r_out_vld;
    logic [IDX_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_div_cnt;

    // Per-item plan and payload registers
    t_op                    r_op;
    logic                   r_div;
    logic                   r_save;
    logic                   r_ireset;
    logic [PH_W-1:0]        r_phase_item;
    logic [MID_W-1:0]       r_pulse   [NUM_SERVOS];
    logic [MID_W-1:0]       r_mid_col [NUM_SERVOS];
    logic [SUM_W-1:0]       r_sum_hold;
    logic [MID_W-1:0]       r_bak_hold;
    logic [SUM_W-1:0]       r_rem;
    logic [SUM_W-1:0]       r_quo;
    logic [((12*NUM_SERVOS+5+7)/8)*8-1:0] r_out_data;

    // Decoded input fields
    logic                   in_arm;
    logic                   in_en;
    logic [TIME_W-1:0]      in_now;
    logic                   in_acc;

    // Next values decided at item acceptance
    logic                   n_start;
    logic                   n_save;
    logic                   n_acc;
    logic                   n_div;
    logic [PH_W-1:0]        n_ph1;
    logic [PH_W-1:0]        n_phase;
    logic [TIME_W-1:0]      n_cs;
    logic [SUM_W-1:0]       n_tick;
    logic [TIME_W-1:0]      n_save_mark;
    t_op                    n_op;

    // Entry update path
    logic [ENT_W-1:0]       ram_rdata;
    logic [ENT_W-1:0]       ram_wdata;
    logic                   ram_we;
    logic [MID_W-1:0]       rd_mid;
    logic [MID_W-1:0]       rd_bak;
    logic [SUM_W-1:0]       rd_sum;
    logic [MID_W-1:0]       upd_mid;
    logic [MID_W-1:0]       upd_bak;
    logic [SUM_W-1:0]       upd_sum;
    logic [SUM_W:0]         div_trial;
    logic                   div_ge;
    logic [MID_W-1:0]       sat_q;
    logic                   last_idx;
    logic [((12*NUM_SERVOS+5+7)/8)*8-1:0] n_out_data;

    assign in_arm = i_s_axis_tdata[ARM_B];
    assign in_en  = i_s_axis_tdata[ARM_B+1];
    assign in_now = i_s_axis_tdata[ARM_B+2 +: TIME_W];
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // Phase decisions for one tick
    always_comb begin
        n_start = in_en && (r_phase == smat_pkg::PH_IDLE) && in_arm;
        n_save  = in_en && (r_phase == smat_pkg::PH_SAVE) && !in_arm
                  && ((in_now - r_save_mark) > TIME_W'(r_save_ms));
        if (!in_en) begin
            n_ph1 = smat_pkg::PH_IDLE;
        end else if (n_start) begin
            n_ph1 = smat_pkg::PH_COLLECT;
        end else if (r_phase == smat_pkg::PH_COLLECT && !in_arm) begin
            n_ph1 = smat_pkg::PH_IDLE;
        end else if (n_save) begin
            n_ph1 = smat_pkg::PH_DONE;
        end else begin
            n_ph1 = r_phase;
        end
        n_save_mark = (in_en && r_phase == smat_pkg::PH_SAVE && in_arm) ? in_now
                                                                        : r_save_mark;
        n_acc  = in_en && (n_ph1 == smat_pkg::PH_COLLECT) && in_arm;
        n_cs   = n_start ? in_now : r_collect_start;
        if (!n_acc) begin
            n_tick = r_tick;
        end else if (n_start) begin
            n_tick = SUM_W'(1);
        end else if (r_tick == {SUM_W{1'b1}}) begin
            n_tick = r_tick;
        end else begin
            n_tick = r_tick + SUM_W'(1);
        end
        n_div   = n_acc && ((in_now - n_cs) > TIME_W'(r_collect_ms));
        n_phase = n_div ? smat_pkg::PH_SAVE : n_ph1;
        if (!in_en && r_phase == smat_pkg::PH_SAVE) begin
            n_op = OP_RESTORE;
        end else if (n_start) begin
            n_op = OP_BACKUP;
        end else if (n_acc) begin
            n_op = OP_ACC;
        end else begin
            n_op = OP_NONE;
        end
    end

    // Entry fields: midpoint low, backup, then sum
    assign rd_mid = r_mid_vld[r_idx] ? ram_rdata[0 +: MID_W] : smat_pkg::MID_RESET;
    assign rd_bak = ram_rdata[MID_W +: MID_W];
    assign rd_sum = ram_rdata[2*MID_W +: SUM_W];

    always_comb begin
        case (r_op)
            OP_BACKUP: begin
                upd_mid = rd_mid;
                upd_bak = rd_mid;
                upd_sum = SUM_W'(r_pulse[r_idx]);
            end
            OP_ACC: begin
                upd_mid = rd_mid;
                upd_bak = rd_bak;
                upd_sum = rd_sum + SUM_W'(r_pulse[r_idx]);
            end
            OP_RESTORE: begin
                upd_mid = rd_bak;
                upd_bak = rd_bak;
                upd_sum = rd_sum;
            end
            default: begin
                upd_mid = rd_mid;
                upd_bak = rd_bak;
                upd_sum = rd_sum;
            end
        endcase
    end

    // Restoring divider step and quotient clamp
    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_tick});
    assign sat_q     = (r_quo[SUM_W-1:MID_W] != '0) ? smat_pkg::MID_MAX : r_quo[MID_W-1:0];

    assign last_idx = (r_idx == IDX_W'(NUM_SERVOS-1));

    // RAM write port
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = {upd_sum, upd_bak, upd_mid};
        if (r_state == ST_MOD && !r_div) begin
            ram_we = 1'b1;
        end else if (r_state == ST_WB) begin
            ram_we    = 1'b1;
            ram_wdata = {r_sum_hold, r_bak_hold, sat_q};
        end
    end

    // Result packing
    always_comb begin
        n_out_data = '0;
        for (int i = 0; i < NUM_SERVOS; i++) begin
            n_out_data[MID_W*i +: MID_W] = r_mid_col[i];
        end
        n_out_data[ARM_B +: PH_W] = r_phase_item;
        n_out_data[ARM_B+2]       = r_save;
        n_out_data[ARM_B+3]       = r_ireset;
        n_out_data[ARM_B+4]       = r_save;
    end

    smat_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SERVOS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Sequencer, scalar state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_phase         <= smat_pkg::PH_IDLE;
            r_tick          <= '0;
            r_collect_start <= '0;
            r_save_mark     <= '0;
            r_collect_ms    <= smat_pkg::COLLECT_DEF;
            r_save_ms       <= smat_pkg::SAVE_DEF;
            r_mid_vld       <= '0;
            r_out_vld       <= 1'b0;
            r_idx           <= '0;
            r_div_cnt       <= '0;
        end else begin
            // Configuration writes
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    smat_pkg::CFG_COLLECT_TIME: r_collect_ms <= i_cfg_wdata;
                    smat_pkg::CFG_SAVE_DELAY:   r_save_ms    <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // Result taken; a finishing item reloads the register itself
            if (r_out_vld && i_m_axis_tready && r_state != ST_DONE) begin
                r_out_vld <= 1'b0;
            end

            if (ram_we) begin
                r_mid_vld[r_idx] <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_phase         <= n_phase;
                        r_tick          <= n_tick;
                        r_collect_start <= n_cs;
                        r_save_mark     <= n_save_mark;
                        r_op            <= n_op;
                        r_div           <= n_div;
                        r_save          <= n_save;
                        r_ireset        <= n_div;
                        r_phase_item    <= n_phase;
                        for (int i = 0; i < NUM_SERVOS; i++) begin
                            r_pulse[i] <= i_s_axis_tdata[MID_W*i +: MID_W];
                        end
                        r_idx   <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    if (r_div) begin
                        r_sum_hold <= upd_sum;
                        r_bak_hold <= upd_bak;
                        r_rem      <= '0;
                        r_quo      <= upd_sum;
                        r_div_cnt  <= '0;
                        r_state    <= ST_DIV;
                    end else begin
                        r_mid_col[r_idx] <= upd_mid;
                        if (last_idx) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem     <= div_ge ? SUM_W'(div_trial - {1'b0, r_tick})
                                        : div_trial[SUM_W-1:0];
                    r_quo     <= {r_quo[SUM_W-2:0], div_ge};
                    r_div_cnt <= r_div_cnt + CNT_W'(1);
                    if (r_div_cnt == CNT_W'(SUM_W-1)) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    r_mid_col[r_idx] <= sat_q;
                    if (last_idx) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= ST_READ;
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out_data <= n_out_data;
                        r_out_vld  <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench for servo_midpoint_autotrim: directed trim cycles, then random sessions.
// Each item is scored against an in-bench model of the trim sequence.
// Depends on smat_pkg and the servo_midpoint_autotrim RTL.

module tb;

    localparam int MID_W  = smat_pkg::MID_W;
    localparam int TIME_W = smat_pkg::TIME_W;
    localparam int PH_W   = smat_pkg::PH_W;
    localparam int CFG_W  = smat_pkg::CFG_W;
    localparam int NSRV  = smat_pkg::NUM_SERVOS_DEF;
    localparam int IN_W  = ((12*NSRV+34+7)/8)*8;
    localparam int OUT_W = ((12*NSRV+5+7)/8)*8;
    localparam int OB    = MID_W*NSRV;   // first bit after the midpoints
    localparam int DRAIN_CYCLES = 150;    // extra wait after the last result, longer than one compute tick

    typedef struct packed {
        logic [TIME_W-1:0]          now;
        logic                       enable;
        logic                       armed;
        logic [NSRV-1:0][MID_W-1:0] pulse;
    } t_servo_tick;

    typedef struct packed {
        logic [NSRV-1:0][MID_W-1:0] middle;
        logic [PH_W-1:0]            phase;
        logic                       save;
        logic                       irst;
        logic                       beep;
    } t_trim_out;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic [IN_W-1:0]  s_data  = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [OUT_W-1:0] m_data;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             cfg_en  = 1'b0;
    logic             cfg_idx = smat_pkg::CFG_COLLECT_TIME;
    logic [CFG_W-1:0] cfg_data = '0;

    always #5 i_clk = ~i_clk;

    servo_midpoint_autotrim #(
        .NUM_SERVOS(NSRV)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_data)
    );

    // Trim model state
    logic [PH_W-1:0]   trim_ph;
    logic [MID_W-1:0]  mid_now  [NSRV];
    logic [MID_W-1:0]  mid_save [NSRV];
    logic [31:0]       pulse_acc [NSRV];
    logic [31:0]       tick_cnt;
    logic [TIME_W-1:0] collect_t0;
    logic [TIME_W-1:0] disarm_mark;
    logic [CFG_W-1:0]  collect_tm;
    logic [CFG_W-1:0]  save_dly;

    t_trim_out trim_expect_q [$];
    int        mismatches = 0;
    int        items_sent = 0;
    bit        no_idle = 1'b0;
    logic [TIME_W-1:0] clock_ms = '0;

    function automatic void reset_trim();
        int i;
        trim_ph = smat_pkg::PH_IDLE;
        for (i = 0; i < NSRV; i++) begin
            mid_now[i]   = smat_pkg::MID_RESET;
            mid_save[i]  = '0;
            pulse_acc[i] = '0;
        end
        tick_cnt    = '0;
        collect_t0  = '0;
        disarm_mark = '0;
        collect_tm  = smat_pkg::COLLECT_DEF;
        save_dly    = smat_pkg::SAVE_DEF;
    endfunction

    // Advance the trim model by one tick and return the expected result
    function automatic t_trim_out trim_step(input t_servo_tick t);
        t_trim_out   r;
        logic [31:0] quo;
        logic [31:0] span;
        int          i;
        r = '0;
        if (t.enable) begin
            if (trim_ph == smat_pkg::PH_IDLE && t.armed) begin
                for (i = 0; i < NSRV; i++) begin
                    mid_save[i]  = mid_now[i];
                    pulse_acc[i] = '0;
                end
                collect_t0 = t.now;
                tick_cnt   = '0;
                trim_ph    = smat_pkg::PH_COLLECT;
            end else if (trim_ph == smat_pkg::PH_COLLECT && !t.armed) begin
                trim_ph = smat_pkg::PH_IDLE;
            end else if (trim_ph == smat_pkg::PH_SAVE) begin
                if (!t.armed) begin
                    span = t.now - disarm_mark;
                    if (span > 32'(save_dly)) begin
                        r.save  = 1'b1;
                        trim_ph = smat_pkg::PH_DONE;
                    end
                end else begin
                    disarm_mark = t.now;
                end
            end
            // Summing also runs on the arming tick
            if (trim_ph == smat_pkg::PH_COLLECT && t.armed) begin
                if (tick_cnt != '1) tick_cnt++;
                for (i = 0; i < NSRV; i++) pulse_acc[i] += 32'(t.pulse[i]);
                span = t.now - collect_t0;
                if (span > 32'(collect_tm)) begin
                    for (i = 0; i < NSRV; i++) begin
                        quo = pulse_acc[i] / tick_cnt;
                        mid_now[i] = (quo > 32'(smat_pkg::MID_MAX)) ? smat_pkg::MID_MAX
                                                                      : quo[MID_W-1:0];
                    end
                    trim_ph = smat_pkg::PH_SAVE;
                    r.irst  = 1'b1;
                end
            end
        end else begin
            // Leaving save pending drops the new midpoints
            if (trim_ph == smat_pkg::PH_SAVE) begin
                for (i = 0; i < NSRV; i++) mid_now[i] = mid_save[i];
            end
            trim_ph = smat_pkg::PH_IDLE;
        end
        for (i = 0; i < NSRV; i++) r.middle[i] = mid_now[i];
        r.phase = trim_ph;
        r.beep  = r.save;
        return r;
    endfunction

    function automatic t_servo_tick tick_of(input int p0, input int p1, input int p2,
                                            input int p3, input bit armed, input bit en,
                                            input logic [TIME_W-1:0] now);
        t_servo_tick t;
        t.pulse[0] = p0[MID_W-1:0];
        t.pulse[1] = p1[MID_W-1:0];
        t.pulse[2] = p2[MID_W-1:0];
        t.pulse[3] = p3[MID_W-1:0];
        t.armed    = armed;
        t.enable   = en;
        t.now      = now;
        return t;
    endfunction

    // Random pulses, with the range ends now and then
    function automatic t_servo_tick rand_tick(input bit armed, input bit en,
                                              input logic [TIME_W-1:0] now);
        t_servo_tick t;
        int i;
        for (i = 0; i < NSRV; i++) begin
            if ($urandom_range(7) == 0)
                t.pulse[i] = $urandom_range(1) ? smat_pkg::MID_MAX : '0;
            else
                t.pulse[i] = MID_W'($urandom_range(4095));
        end
        t.armed  = armed;
        t.enable = en;
        t.now    = now;
        return t;
    endfunction

    // Send one tick item; may leave valid high, callers lower it before other waits
    task automatic send_tick(input t_servo_tick t);
        trim_expect_q.push_back(trim_step(t));
        items_sent++;
        s_data  <= IN_W'(t);
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!s_ready);
        if (!no_idle) begin
            while ($urandom_range(99) < 35) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic step_send(input int dt_max, input bit armed, input bit en);
        clock_ms += TIME_W'($urandom_range(0, dt_max));
        send_tick(rand_tick(armed, en, clock_ms));
    endtask

    // Stop input and let every outstanding result drain
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (trim_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_en   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_en <= 1'b0;
        if (idx == smat_pkg::CFG_COLLECT_TIME) collect_tm = value;
        else save_dly = value;
        @(posedge i_clk);
    endtask

    // Full cycle with reset settings; first disarm compares against the old mark
    task automatic test_default_cycle();
        send_tick(tick_of(4095, 4095, 4095, 4095, 0, 0, 32'd0));
        send_tick(tick_of(0, 0, 0, 0, 1, 0, 32'd5));
        send_tick(tick_of(1000, 2000, 3000, 4000, 0, 1, 32'd10));
        send_tick(tick_of(0, 4095, 1500, 2048, 1, 1, 32'd1000));
        send_tick(tick_of(4095, 0, 1501, 2047, 1, 1, 32'd3000));
        send_tick(tick_of(4095, 4095, 7, 1, 1, 1, 32'd3001));
        send_tick(tick_of(100, 200, 300, 400, 0, 1, 32'd3002));
        send_tick(tick_of(1, 2, 3, 4, 1, 1, 32'd3003));
        send_tick(tick_of(1, 2, 3, 4, 1, 0, 32'd3004));
    endtask

    // Disable in save pending brings back the old midpoints; disarm aborts collecting
    task automatic test_restore_and_abort();
        send_tick(tick_of(10, 20, 30, 40, 1, 1, 32'd5000));
        send_tick(tick_of(4000, 3000, 2000, 1000, 1, 1, 32'd7001));
        send_tick(tick_of(0, 0, 0, 0, 1, 1, 32'd7100));
        send_tick(tick_of(0, 0, 0, 0, 0, 1, 32'd9600));
        send_tick(tick_of(0, 0, 0, 0, 0, 0, 32'd9601));
        send_tick(tick_of(2222, 2222, 2222, 2222, 1, 1, 32'd10000));
        send_tick(tick_of(2222, 2222, 2222, 2222, 0, 1, 32'd10001));
    endtask

    // Register ends, with time wrapping through zero
    task automatic test_register_extremes();
        wait_quiet();
        write_reg(smat_pkg::CFG_COLLECT_TIME, '0);
        write_reg(smat_pkg::CFG_SAVE_DELAY, '0);
        send_tick(tick_of(4095, 0, 4095, 0, 1, 1, 32'hFFFF_FFFE));
        send_tick(tick_of(0, 4095, 0, 4095, 1, 1, 32'hFFFF_FFFF));
        send_tick(tick_of(0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF));
        send_tick(tick_of(0, 0, 0, 0, 0, 0, 32'h0000_0000));
        wait_quiet();
        write_reg(smat_pkg::CFG_COLLECT_TIME, '1);
        write_reg(smat_pkg::CFG_SAVE_DELAY, '1);
        send_tick(tick_of(1500, 1600, 1700, 1800, 1, 1, 32'hFFFF_FFF0));
        send_tick(tick_of(1400, 1300, 1200, 1100, 1, 1, 32'h0000_FFEF));
        send_tick(tick_of(1500, 1500, 1500, 1500, 1, 1, 32'h0000_FFF0));
        send_tick(tick_of(0, 0, 0, 0, 1, 1, 32'd5));
        send_tick(tick_of(0, 0, 0, 0, 0, 1, 32'd65540));
        send_tick(tick_of(0, 0, 0, 0, 0, 1, 32'd65541));
        send_tick(tick_of(0, 0, 0, 0, 0, 0, 32'd65542));
    endtask

    // One random session: mostly a proper trim sequence, sometimes noise
    task automatic run_session();
        int dt_c;
        int dt_s;
        int cap;
        dt_c = int'(collect_tm) / 4 + 2;
        dt_s = int'(save_dly) / 4 + 2;
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(3) == 0) clock_ms = TIME_W'($urandom);
                step_send(dt_c, $urandom_range(1), $urandom_range(1));
            end
        end else begin
            repeat ($urandom_range(1, 3)) step_send(50, $urandom_range(1), 1'b0);
            cap = 0;
            do begin
                step_send(dt_c, 1'b1, 1'b1);
                cap++;
            end while (trim_ph == smat_pkg::PH_COLLECT && cap < 40);
            if (trim_ph == smat_pkg::PH_SAVE) begin
                repeat ($urandom_range(0, 3)) step_send(dt_s, 1'b1, 1'b1);
                if ($urandom_range(99) < 20) begin
                    step_send(dt_s, $urandom_range(1), 1'b0);
                end else begin
                    cap = 0;
                    do begin
                        step_send(dt_s, 1'b0, 1'b1);
                        cap++;
                    end while (trim_ph == smat_pkg::PH_SAVE && cap < 40);
                    repeat ($urandom_range(0, 2)) step_send(dt_s, $urandom_range(1), 1'b1);
                end
            end
        end
    endtask

    task automatic test_random_sessions();
        int set;
        int goal;
        goal = items_sent;
        clock_ms = TIME_W'($urandom);
        for (set = 0; set < 8; set++) begin
            wait_quiet();
            case (set)
                0: begin
                    write_reg(smat_pkg::CFG_COLLECT_TIME, '0);
                    write_reg(smat_pkg::CFG_SAVE_DELAY, '0);
                end
                1: begin
                    write_reg(smat_pkg::CFG_COLLECT_TIME, '1);
                    write_reg(smat_pkg::CFG_SAVE_DELAY, '1);
                end
                default: begin
                    write_reg(smat_pkg::CFG_COLLECT_TIME, (set % 3 == 2) ?
                              CFG_W'($urandom_range(0, 65535)) : CFG_W'($urandom_range(0, 40)));
                    write_reg(smat_pkg::CFG_SAVE_DELAY, (set % 3 == 1) ?
                              CFG_W'($urandom_range(0, 65535)) : CFG_W'($urandom_range(0, 40)));
                end
            endcase
            no_idle = (set == 4);
            goal += 225;
            while (items_sent < goal) run_session();
        end
        no_idle = 1'b0;
    endtask

    // Score each accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_trim_out got;
        t_trim_out want;
        if (rst_n && m_valid && m_ready) begin
            got.middle = m_data[OB-1:0];
            got.phase  = m_data[OB +: PH_W];
            got.save   = m_data[OB+2];
            got.irst   = m_data[OB+3];
            got.beep   = m_data[OB+4];
            if (trim_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %h", got);
            end else begin
                want = trim_expect_q.pop_front();
                if (got.middle !== want.middle || got.phase !== want.phase ||
                    got.save !== want.save || got.irst !== want.irst ||
                    got.beep !== want.beep) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: middle %h/%h phase %0d/%0d save %b/%b ",
                                  "irst %b/%b beep %b/%b (expected/actual)"},
                                 want.middle, got.middle, want.phase, got.phase,
                                 want.save, got.save, want.irst, got.irst,
                                 want.beep, got.beep);
                end
            end
        end
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end

    initial begin
        reset_trim();
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_cycle();
        test_restore_and_abort();
        test_register_extremes();
        test_random_sessions();
        wait_quiet();
        if (mismatches == 0 && trim_expect_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### servo_midpoint_autotrim.f
sv/smat_pkg.sv
sv/smat_ram.sv
sv/servo_midpoint_autotrim.sv
verif/tb.sv
